### rtl/core/bkb_pkg.sv
// shared types and constants of the bokeh kernel blur
package bkb_pkg;

    localparam logic [1:0] OP_KER  = 2'd0;
    localparam logic [1:0] OP_IMG  = 2'd1;
    localparam logic [1:0] OP_CMP  = 2'd2;

    localparam logic [2:0] CFG_RADIUS = 3'd0;
    localparam logic [2:0] CFG_IMG_W  = 3'd1;
    localparam logic [2:0] CFG_IMG_H  = 3'd2;
    localparam logic [2:0] CFG_KER_W  = 3'd3;
    localparam logic [2:0] CFG_KER_H  = 3'd4;

    localparam int CFG_DATA_W = 7;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  pos_x;
        logic [5:0]  pos_y;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic        inside_req;
    } t_in;

    typedef struct packed {
        logic [5:0]  out_x;
        logic [5:0]  out_y;
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [15:0] out_alpha;
    } t_out;

    typedef struct packed {
        logic wr_ker;
        logic wr_img;
        logic load_req;
        logic cent_rd;
        logic div_setup_load;
        logic div_chan_load;
        logic div_step;
        logic win_start;
        logic win_step;
        logic emit_pass;
        logic emit_div;
    } t_cmd;

    typedef struct packed {
        logic cent_mask;
        logic win_last;
        logic div_done;
    } t_sts;

endpackage

### rtl/core/bkb_ctrl.sv
// controller state machine of the bokeh kernel blur
module bkb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_op,
    input  bkb_pkg::t_sts i_sts,
    output bkb_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import bkb_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CENT   = 4'd1;
    localparam logic [3:0] S_CHK    = 4'd2;
    localparam logic [3:0] S_SETUP  = 4'd3;
    localparam logic [3:0] S_WSTART = 4'd4;
    localparam logic [3:0] S_WIN    = 4'd5;
    localparam logic [3:0] S_DR1    = 4'd6;
    localparam logic [3:0] S_DR2    = 4'd7;
    localparam logic [3:0] S_DIVL   = 4'd8;
    localparam logic [3:0] S_DIV    = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;

    logic [3:0] r_state, n_state;
    logic       accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.wr_ker   = (i_op == OP_KER);
                    o_cmd.wr_img   = (i_op == OP_IMG);
                    o_cmd.load_req = (i_op == OP_CMP);
                    if (i_op == OP_CMP) begin
                        n_state = S_CENT;
                    end
                end
            end
            S_CENT: begin
                o_cmd.cent_rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.cent_mask) begin
                    o_cmd.div_setup_load = 1'b1;
                    n_state = S_SETUP;
                end else begin
                    o_cmd.emit_pass = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SETUP: begin
                if (i_sts.div_done) begin
                    n_state = S_WSTART;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_WSTART: begin
                o_cmd.win_start = 1'b1;
                n_state = S_WIN;
            end
            S_WIN: begin
                o_cmd.win_step = 1'b1;
                if (i_sts.win_last) begin
                    n_state = S_DR1;
                end
            end
            S_DR1: n_state = S_DR2;
            S_DR2: n_state = S_DIVL;
            S_DIVL: begin
                o_cmd.div_chan_load = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_EMIT: begin
                o_cmd.emit_div = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/bkb_dp.sv
// datapath of the bokeh kernel blur: stores, window walk, accumulators, dividers
module bkb_dp #(
    parameter int MAX_RADIUS     = 8,
    parameter int MAX_IMAGE_DIM  = 64,
    parameter int MAX_KERNEL_DIM = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bkb_pkg::t_cmd                       i_cmd,
    input  bkb_pkg::t_in                        i_item,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_index,
    input  logic [bkb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output bkb_pkg::t_sts                       o_sts,
    output logic                                o_res_valid,
    output bkb_pkg::t_out                       o_res
);
    import bkb_pkg::*;

    localparam int WIN_N   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int ACC_EXT = $clog2(WIN_N);
    localparam int NUM_W   = 32 + ACC_EXT;
    localparam int DEN_W   = 16 + ACC_EXT;
    localparam int DCW     = $clog2(NUM_W + 1);
    localparam int RW      = $clog2(MAX_RADIUS + 1);
    localparam int CW      = $clog2(2 * MAX_RADIUS + 1);
    localparam int IAW     = $clog2(MAX_IMAGE_DIM);
    localparam int IDW     = $clog2(MAX_IMAGE_DIM + 1);
    localparam int KAW     = $clog2(MAX_KERNEL_DIM);
    localparam int KDW     = $clog2(MAX_KERNEL_DIM + 1);
    localparam int DW      = $clog2(4 * MAX_RADIUS + 3);
    localparam int SW      = ((IAW > RW) ? IAW : RW) + 2;
    localparam int IMG_D   = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
    localparam int KER_D   = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
    localparam int IMADW   = $clog2(IMG_D);
    localparam int KMADW   = $clog2(KER_D);

    logic [3:0] r_cfg_rad;
    logic [6:0] r_cfg_iw, r_cfg_ih;
    logic [5:0] r_cfg_kw, r_cfg_kh;

    logic [RW-1:0]  rr;
    logic [IDW-1:0] iw, ih;
    logic [KDW-1:0] kw, kh;
    logic [IAW-1:0] cx, cy;
    logic [DW-1:0]  dd;
    logic [CW-1:0]  two_r;

    logic [64:0] r_img_mem [IMG_D];
    logic [63:0] r_ker_mem [KER_D];
    logic [64:0] r_img_q;
    logic [63:0] r_ker_q;
    logic [IMADW-1:0] img_raddr, img_waddr, win_iaddr, cent_addr;
    logic [KMADW-1:0] ker_raddr, ker_waddr;

    logic [5:0] r_px, r_py;

    logic [CW-1:0]  r_wx, r_wy;
    logic signed [SW-1:0] r_ax, r_ay, ax0, ay0;
    logic [KAW-1:0] r_tqx, r_tqy, n_tqx, n_tqy;
    logic [DW-1:0]  r_trx, r_try, n_trx, n_try;
    logic [KAW-1:0] qsx, qsy;
    logic [DW-1:0]  rsx, rsy;
    logic [IAW-1:0] sx, sy;

    logic              r_v1, r_v2;
    logic [31:0]       r_prod [4];
    logic [15:0]       r_kw2 [4];
    logic [NUM_W-1:0]  r_csum [4];
    logic [DEN_W-1:0]  r_wsum [4];

    logic [NUM_W-1:0]  r_num [4];
    logic [DEN_W-1:0]  r_rem [4];
    logic [DEN_W-1:0]  r_den [4];
    logic [DCW-1:0]    r_dcnt;
    logic [NUM_W-1:0]  su_num [4];
    logic [15:0]       quo [4];

    logic   r_out_vld;
    t_out   r_out;

    // effective settings
    always_comb begin
        rr = (32'(r_cfg_rad) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_cfg_rad);
        if (r_cfg_iw == '0) iw = IDW'(1);
        else if (32'(r_cfg_iw) > MAX_IMAGE_DIM) iw = IDW'(MAX_IMAGE_DIM);
        else iw = IDW'(r_cfg_iw);
        if (r_cfg_ih == '0) ih = IDW'(1);
        else if (32'(r_cfg_ih) > MAX_IMAGE_DIM) ih = IDW'(MAX_IMAGE_DIM);
        else ih = IDW'(r_cfg_ih);
        if (r_cfg_kw == '0) kw = KDW'(1);
        else if (32'(r_cfg_kw) > MAX_KERNEL_DIM) kw = KDW'(MAX_KERNEL_DIM);
        else kw = KDW'(r_cfg_kw);
        if (r_cfg_kh == '0) kh = KDW'(1);
        else if (32'(r_cfg_kh) > MAX_KERNEL_DIM) kh = KDW'(MAX_KERNEL_DIM);
        else kh = KDW'(r_cfg_kh);
        cx = (32'(r_px) < 32'(iw)) ? IAW'(r_px) : IAW'(iw - IDW'(1));
        cy = (32'(r_py) < 32'(ih)) ? IAW'(r_py) : IAW'(ih - IDW'(1));
        dd = DW'(32'(rr) * 4 + 2);
        two_r = CW'(32'(rr) * 2);
        ax0 = $signed(SW'(cx)) - $signed(SW'(rr));
        ay0 = $signed(SW'(cy)) - $signed(SW'(rr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rad <= 4'd0;
            r_cfg_iw  <= 7'd64;
            r_cfg_ih  <= 7'd64;
            r_cfg_kw  <= 6'd32;
            r_cfg_kh  <= 6'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RADIUS: r_cfg_rad <= i_cfg_data[3:0];
                CFG_IMG_W:  r_cfg_iw  <= i_cfg_data[6:0];
                CFG_IMG_H:  r_cfg_ih  <= i_cfg_data[6:0];
                CFG_KER_W:  r_cfg_kw  <= i_cfg_data[5:0];
                CFG_KER_H:  r_cfg_kh  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // stores
    assign img_waddr = IMADW'(32'(i_item.pos_y) * MAX_IMAGE_DIM + 32'(i_item.pos_x));
    assign ker_waddr = KMADW'(32'(i_item.pos_y) * MAX_KERNEL_DIM + 32'(i_item.pos_x));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_img && 32'(i_item.pos_x) < MAX_IMAGE_DIM
                && 32'(i_item.pos_y) < MAX_IMAGE_DIM) begin
            r_img_mem[img_waddr] <= {i_item.inside_req, i_item.alpha, i_item.blue,
                                     i_item.green, i_item.red};
        end
        r_img_q <= r_img_mem[img_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_ker && 32'(i_item.pos_x) < MAX_KERNEL_DIM
                && 32'(i_item.pos_y) < MAX_KERNEL_DIM) begin
            r_ker_mem[ker_waddr] <= {i_item.alpha, i_item.blue, i_item.green, i_item.red};
        end
        r_ker_q <= r_ker_mem[ker_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_px <= i_item.pos_x;
            r_py <= i_item.pos_y;
        end
    end

    // window walk
    always_comb begin
        if (r_ax < 0) sx = '0;
        else if (r_ax >= $signed(SW'(iw))) sx = IAW'(iw - IDW'(1));
        else sx = IAW'(r_ax);
        if (r_ay < 0) sy = '0;
        else if (r_ay >= $signed(SW'(ih))) sy = IAW'(ih - IDW'(1));
        else sy = IAW'(r_ay);
        win_iaddr = IMADW'(32'(sy) * MAX_IMAGE_DIM + 32'(sx));
        cent_addr = IMADW'(32'(cy) * MAX_IMAGE_DIM + 32'(cx));
        img_raddr = i_cmd.cent_rd ? cent_addr : win_iaddr;
        ker_raddr = KMADW'(32'(r_tqy) * MAX_KERNEL_DIM + 32'(r_tqx));
        qsx = KAW'(r_num[1]);
        rsx = DW'(r_rem[1]);
        qsy = KAW'(r_num[3]);
        rsy = DW'(r_rem[3]);
        if (r_trx < rsx) begin
            n_trx = DW'(({1'b0, r_trx} + {1'b0, dd}) - {1'b0, rsx});
            n_tqx = r_tqx - qsx - KAW'(1);
        end else begin
            n_trx = r_trx - rsx;
            n_tqx = r_tqx - qsx;
        end
        if (r_try < rsy) begin
            n_try = DW'(({1'b0, r_try} + {1'b0, dd}) - {1'b0, rsy});
            n_tqy = r_tqy - qsy - KAW'(1);
        end else begin
            n_try = r_try - rsy;
            n_tqy = r_tqy - qsy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_start) begin
            r_wx  <= '0;
            r_wy  <= '0;
            r_ax  <= ax0;
            r_ay  <= ay0;
            r_tqx <= KAW'(r_num[0]);
            r_trx <= DW'(r_rem[0]);
            r_tqy <= KAW'(r_num[2]);
            r_try <= DW'(r_rem[2]);
        end else if (i_cmd.win_step) begin
            if (r_wx == two_r) begin
                r_wx  <= '0;
                r_ax  <= ax0;
                r_tqx <= KAW'(r_num[0]);
                r_trx <= DW'(r_rem[0]);
                r_wy  <= r_wy + CW'(1);
                r_ay  <= r_ay + SW'(1);
                r_tqy <= n_tqy;
                r_try <= n_try;
            end else begin
                r_wx  <= r_wx + CW'(1);
                r_ax  <= r_ax + SW'(1);
                r_tqx <= n_tqx;
                r_trx <= n_trx;
            end
        end
    end

    // multiply and accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.win_step;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_prod[c] <= r_img_q[16*c +: 16] * r_ker_q[16*c +: 16];
            r_kw2[c]  <= r_ker_q[16*c +: 16];
            if (i_cmd.win_start) begin
                r_csum[c] <= '0;
                r_wsum[c] <= '0;
            end else if (r_v2) begin
                r_csum[c] <= r_csum[c] + NUM_W'(r_prod[c]);
                r_wsum[c] <= r_wsum[c] + DEN_W'(r_kw2[c]);
            end
        end
    end

    // four restoring divider lanes, one bit a cycle
    always_comb begin
        su_num[0] = NUM_W'((32'(rr) * 4 + 1) * (32'(kw) - 1));
        su_num[1] = NUM_W'(2 * (32'(kw) - 1));
        su_num[2] = NUM_W'((32'(rr) * 4 + 1) * (32'(kh) - 1));
        su_num[3] = NUM_W'(2 * (32'(kh) - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_setup_load || i_cmd.div_chan_load) begin
            r_dcnt <= DCW'(NUM_W);
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            logic [DEN_W:0] sh;
            sh = {r_rem[l], r_num[l][NUM_W-1]};
            if (i_cmd.div_setup_load) begin
                r_num[l] <= su_num[l];
                r_den[l] <= DEN_W'(dd);
                r_rem[l] <= '0;
            end else if (i_cmd.div_chan_load) begin
                r_num[l] <= r_csum[l];
                r_den[l] <= r_wsum[l];
                r_rem[l] <= '0;
            end else if (i_cmd.div_step) begin
                if (sh >= {1'b0, r_den[l]}) begin
                    r_rem[l] <= DEN_W'(sh - {1'b0, r_den[l]});
                    r_num[l] <= {r_num[l][NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[l] <= DEN_W'(sh);
                    r_num[l] <= {r_num[l][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (r_wsum[c] == '0) quo[c] = '0;
            else if (|r_num[c][NUM_W-1:16]) quo[c] = 16'hFFFF;
            else quo[c] = r_num[c][15:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.emit_pass || i_cmd.emit_div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pass) begin
            r_out <= {r_px, r_py, r_img_q[15:0], r_img_q[31:16],
                      r_img_q[47:32], r_img_q[63:48]};
        end else if (i_cmd.emit_div) begin
            r_out <= {r_px, r_py, quo[0], quo[1], quo[2], quo[3]};
        end
    end

    assign o_sts.cent_mask = r_img_q[64];
    assign o_sts.win_last  = (r_wx == two_r) && (r_wy == two_r);
    assign o_sts.div_done  = (r_dcnt == '0);
    assign o_res_valid     = r_out_vld;
    assign o_res           = r_out;

endmodule

### rtl/core/bokeh_kernel_blur.sv
// top level of the bokeh kernel blur
// usage:
//   an item is taken when i_start is high and o_busy is low; i_item.op selects it:
//   kernel texel write, image pixel write (with inside flag) or compute request.
//   writes leave o_busy low; writes past the store size are dropped.
//   a compute request raises o_busy until its result is issued.
//   a masked-out centre pixel is passed through as the result on o_res.
//   a blurred pixel is worked in order: a bit-serial divider pass for the texel steps,
//   one store read per window position, then a divider pass for the four channel
//   quotients; the dividers are NUM_W bits wide, NUM_W = 41 at the default sizes.
//   items are worked on one at a time; the next one is taken at the edge ending the result.
//   the result sits on o_res for one cycle with o_res_valid high; the receiver
//   cannot stall, so it must take it then.
//   configuration uses i_cfg_valid / o_cfg_ready (always ready), register index and data;
//   the user must write it only while no compute request is open; unchecked by the block.
//   synchronous reset restores default settings and drops any open request;
//   the stores are not cleared and must be written before they are read.
module bokeh_kernel_blur #(
    parameter int MAX_RADIUS     = 8,
    parameter int MAX_IMAGE_DIM  = 64,
    parameter int MAX_KERNEL_DIM = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  bkb_pkg::t_in                   i_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [2:0]                     i_cfg_index,
    input  logic [bkb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_res_valid,
    output bkb_pkg::t_out                  o_res
);
    import bkb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bkb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_item.op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    bkb_dp #(
        .MAX_RADIUS     (MAX_RADIUS),
        .MAX_IMAGE_DIM  (MAX_IMAGE_DIM),
        .MAX_KERNEL_DIM (MAX_KERNEL_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

### rtl/core/bkb_chk.sv
// port checker of the bokeh kernel blur and its bind
module bkb_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input bkb_pkg::t_in  i_item,
    input logic          o_busy,
    input logic          o_res_valid
);
    import bkb_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_busy && !o_res_valid)
        else $error("not idle after reset");

    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_item.op != OP_CMP |=> !o_busy && !o_res_valid)
        else $error("non-compute item made the block busy or gave a result");

    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(o_busy) && !o_busy)
        else $error("result without an open compute request");

endmodule

bind bokeh_kernel_blur bkb_chk u_bkb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .i_item      (i_item),
    .o_busy      (o_busy),
    .o_res_valid (o_res_valid)
);

### dv/bkb_checker.sv
// checker for the bokeh kernel blur: predicts each computed pixel and compares results
`timescale 1ns / 1ps
module bkb_checker #(
    parameter int MAX_RADIUS     = 8,
    parameter int MAX_IMAGE_DIM  = 64,
    parameter int MAX_KERNEL_DIM = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  bkb_pkg::t_in                   i_item,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [2:0]                     i_cfg_index,
    input  logic [bkb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_res_valid,
    input  bkb_pkg::t_out                  i_res,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_pix_seen,
    output int                             o_blur_seen
);
    import bkb_pkg::*;

    logic [15:0] img_ch [MAX_IMAGE_DIM*MAX_IMAGE_DIM][4];
    logic        img_in [MAX_IMAGE_DIM*MAX_IMAGE_DIM];
    logic [15:0] ker_ch [MAX_KERNEL_DIM*MAX_KERNEL_DIM][4];
    logic [3:0]  radius_q;
    logic [6:0]  img_w_q, img_h_q;
    logic [5:0]  ker_w_q, ker_h_q;
    t_out        blur_q[$];
    int          fails, pix_seen, blur_seen;

    assign o_fail_count = fails;
    assign o_pending    = blur_q.size();
    assign o_pix_seen   = pix_seen;
    assign o_blur_seen  = blur_seen;

    function automatic int dim_clamp(int v, int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int edge_clamp(int c, int dim);
        if (c < 0) return 0;
        if (c >= dim) return dim - 1;
        return c;
    endfunction

    function automatic int tap_index(int j, int r, int kdim);
        return ((2*j + 1) * (kdim - 1)) / (2 * (2*r + 1));
    endfunction

    function automatic t_out blur_pixel(t_in it);
        int          iw, ih, kw, kh, r, cx, cy, sx, sy, tx, ty, cidx;
        longint unsigned csum[4], wsum[4], q;
        logic [15:0] res[4];
        t_out        o;
        iw = dim_clamp(img_w_q, MAX_IMAGE_DIM);
        ih = dim_clamp(img_h_q, MAX_IMAGE_DIM);
        kw = dim_clamp(ker_w_q, MAX_KERNEL_DIM);
        kh = dim_clamp(ker_h_q, MAX_KERNEL_DIM);
        r  = (radius_q > MAX_RADIUS) ? MAX_RADIUS : radius_q;
        cx = (it.pos_x < iw) ? it.pos_x : iw - 1;
        cy = (it.pos_y < ih) ? it.pos_y : ih - 1;
        cidx = cy * MAX_IMAGE_DIM + cx;
        for (int c = 0; c < 4; c++) begin
            csum[c] = 0;
            wsum[c] = 0;
            res[c]  = img_ch[cidx][c];
        end
        if (img_in[cidx]) begin
            for (int wy = 0; wy <= 2*r; wy++) begin
                sy = edge_clamp(cy + wy - r, ih);
                ty = tap_index(2*r - wy, r, kh);
                for (int wx = 0; wx <= 2*r; wx++) begin
                    sx = edge_clamp(cx + wx - r, iw);
                    tx = tap_index(2*r - wx, r, kw);
                    for (int c = 0; c < 4; c++) begin
                        csum[c] += longint'(img_ch[sy*MAX_IMAGE_DIM + sx][c])
                                 * longint'(ker_ch[ty*MAX_KERNEL_DIM + tx][c]);
                        wsum[c] += ker_ch[ty*MAX_KERNEL_DIM + tx][c];
                    end
                end
            end
            for (int c = 0; c < 4; c++) begin
                if (wsum[c] == 0) begin
                    res[c] = '0;
                end else begin
                    q = csum[c] / wsum[c];
                    res[c] = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
                end
            end
        end
        o.out_x     = it.pos_x;
        o.out_y     = it.pos_y;
        o.out_red   = res[0];
        o.out_green = res[1];
        o.out_blue  = res[2];
        o.out_alpha = res[3];
        return o;
    endfunction

    initial begin
        fails = 0;
        pix_seen = 0;
        blur_seen = 0;
        foreach (img_in[i]) begin
            img_in[i] = 1'b0;
            for (int c = 0; c < 4; c++) img_ch[i][c] = '0;
        end
        foreach (ker_ch[i]) for (int c = 0; c < 4; c++) ker_ch[i][c] = '0;
    end

    always @(posedge i_clk) begin
        t_out exp_px;
        if (!i_rst_n) begin
            radius_q = 4'd0;
            img_w_q  = 7'd64;
            img_h_q  = 7'd64;
            ker_w_q  = 6'd32;
            ker_h_q  = 6'd32;
            blur_q.delete();
        end else begin
            if (i_res_valid) begin
                pix_seen++;
                if (blur_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, i_res);
                end else begin
                    exp_px = blur_q.pop_front();
                    if (i_res.out_x !== exp_px.out_x || i_res.out_y !== exp_px.out_y
                        || i_res.out_red !== exp_px.out_red
                        || i_res.out_green !== exp_px.out_green
                        || i_res.out_blue !== exp_px.out_blue
                        || i_res.out_alpha !== exp_px.out_alpha) begin
                        fails++;
                        $display("%0t: pixel mismatch, expected %h, actual %h",
                                 $time, exp_px, i_res);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RADIUS: radius_q = i_cfg_data[3:0];
                    CFG_IMG_W:  img_w_q  = i_cfg_data[6:0];
                    CFG_IMG_H:  img_h_q  = i_cfg_data[6:0];
                    CFG_KER_W:  ker_w_q  = i_cfg_data[5:0];
                    CFG_KER_H:  ker_h_q  = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                case (i_item.op)
                    OP_KER: begin
                        if (i_item.pos_x < MAX_KERNEL_DIM && i_item.pos_y < MAX_KERNEL_DIM) begin
                            ker_ch[i_item.pos_y*MAX_KERNEL_DIM + i_item.pos_x][0] = i_item.red;
                            ker_ch[i_item.pos_y*MAX_KERNEL_DIM + i_item.pos_x][1] = i_item.green;
                            ker_ch[i_item.pos_y*MAX_KERNEL_DIM + i_item.pos_x][2] = i_item.blue;
                            ker_ch[i_item.pos_y*MAX_KERNEL_DIM + i_item.pos_x][3] = i_item.alpha;
                        end
                    end
                    OP_IMG: begin
                        if (i_item.pos_x < MAX_IMAGE_DIM && i_item.pos_y < MAX_IMAGE_DIM) begin
                            img_ch[i_item.pos_y*MAX_IMAGE_DIM + i_item.pos_x][0] = i_item.red;
                            img_ch[i_item.pos_y*MAX_IMAGE_DIM + i_item.pos_x][1] = i_item.green;
                            img_ch[i_item.pos_y*MAX_IMAGE_DIM + i_item.pos_x][2] = i_item.blue;
                            img_ch[i_item.pos_y*MAX_IMAGE_DIM + i_item.pos_x][3] = i_item.alpha;
                            img_in[i_item.pos_y*MAX_IMAGE_DIM + i_item.pos_x] = i_item.inside_req;
                        end
                    end
                    OP_CMP: begin
                        exp_px = blur_pixel(i_item);
                        blur_q.push_back(exp_px);
                        blur_seen++;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

### dv/bokeh_kernel_blur_tb.sv
// testbench top of the bokeh kernel blur: stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module bokeh_kernel_blur_tb;
    import bkb_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int N_PHASE   = 8;
    localparam int PHASE_LEN = 58;
    localparam int BAND      = 4;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_in                   i_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [2:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_res_valid;
    t_out                  o_res;
    int                    fail_count, pending, pix_seen, blur_seen;
    int                    idle_pct;

    bokeh_kernel_blur u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    bkb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_item       (i_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_res_valid  (o_res_valid),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_pix_seen   (pix_seen),
        .o_blur_seen  (blur_seen)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic t_in make_item(logic [1:0] op, int x, int y, logic [15:0] r,
                                      logic [15:0] g, logic [15:0] b, logic [15:0] a,
                                      logic inside_flag);
        t_in it;
        it.op = op;
        it.pos_x = 6'(x);
        it.pos_y = 6'(y);
        it.red = r;
        it.green = g;
        it.blue = b;
        it.alpha = a;
        it.inside_req = inside_flag;
        return it;
    endfunction

    task automatic send(t_in it);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(int r, int iw, int ih, int kw, int kh);
        cfg_write(CFG_RADIUS, r);
        cfg_write(CFG_IMG_W, iw);
        cfg_write(CFG_IMG_H, ih);
        cfg_write(CFG_KER_W, kw);
        cfg_write(CFG_KER_H, kh);
        @(posedge i_clk);
    endtask

    task automatic random_item();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            send(make_item(OP_CMP, $urandom_range(63), $urandom_range(63), rand_chan(),
                           rand_chan(), rand_chan(), rand_chan(), rand_bit()));
        else if (sel < 70)
            send(make_item(OP_IMG, $urandom_range(63), $urandom_range(63), rand_chan(),
                           rand_chan(), rand_chan(), rand_chan(), rand_bit()));
        else if (sel < 95)
            send(make_item(OP_KER, $urandom_range(63), $urandom_range(63), rand_chan(),
                           rand_chan(), rand_chan(), rand_chan(), rand_bit()));
        else
            send(make_item(OP_NONE, $urandom_range(63), $urandom_range(63), rand_chan(),
                           rand_chan(), rand_chan(), rand_chan(), rand_bit()));
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_pct    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill a row band and a column band of each store; geometry stays inside them
        for (int y = 0; y < 32; y++)
            for (int x = 0; x < 32; x++)
                if (y < BAND || x < BAND)
                    send(make_item(OP_KER, x, y, rand_chan(), rand_chan(), rand_chan(),
                                   rand_chan(), 1'b0));
        for (int y = 0; y < 64; y++)
            for (int x = 0; x < 64; x++)
                if (y < BAND || x < BAND)
                    send(make_item(OP_IMG, x, y, rand_chan(), rand_chan(), rand_chan(),
                                   rand_chan(), rand_bit()));
        drain();

        // directed: single tap kernel with a zero red weight, extremes, pass-through
        set_geometry(0, 64, 64, 1, 1);
        send(make_item(OP_KER, 0, 0, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 1'b0));
        send(make_item(OP_KER, 63, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send(make_item(OP_IMG, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send(make_item(OP_IMG, 63, 63, 16'h0000, 16'h1234, 16'hFFFF, 16'h0000, 1'b0));
        send(make_item(OP_CMP, 0, 0, '0, '0, '0, '0, 1'b0));
        send(make_item(OP_CMP, 63, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send(make_item(OP_NONE, 5, 5, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 1'b1));
        drain();
        set_geometry(15, 127, 0, 63, 0);
        send(make_item(OP_CMP, 0, 0, '0, '0, '0, '0, 1'b0));
        send(make_item(OP_CMP, 63, 63, '0, '0, '0, '0, 1'b0));
        send(make_item(OP_CMP, 31, 40, '0, '0, '0, '0, 1'b0));
        drain();
        set_geometry(8, 4, 64, 32, 3);
        send(make_item(OP_IMG, 2, 9, rand_chan(), rand_chan(), rand_chan(), rand_chan(), 1'b1));
        send(make_item(OP_CMP, 2, 9, '0, '0, '0, '0, 1'b0));
        send(make_item(OP_CMP, 60, 0, '0, '0, '0, '0, 1'b0));
        send(make_item(OP_CMP, 0, 63, '0, '0, '0, '0, 1'b0));
        drain();

        for (int ph = 0; ph < N_PHASE; ph++) begin
            case (ph)
                0: set_geometry(0, 64, BAND, 32, BAND);
                1: set_geometry(8, 64, BAND, 32, BAND);
                2: set_geometry(3, 1, 1, 1, 1);
                3: set_geometry(5, BAND, 64, BAND, 32);
                4: set_geometry(1, 64, 1, 32, 2);
                5: set_geometry(15, 127, 3, 63, 2);
                6: set_geometry(15, 2, 127, 3, 63);
                default: begin
                    if ($urandom_range(1) == 0)
                        set_geometry($urandom_range(15), $urandom_range(127),
                                     $urandom_range(BAND), $urandom_range(63),
                                     $urandom_range(BAND));
                    else
                        set_geometry($urandom_range(15), $urandom_range(BAND),
                                     $urandom_range(127), $urandom_range(BAND),
                                     $urandom_range(63));
                end
            endcase
            idle_pct = (ph < 3) ? 7 : (ph < 6) ? 54 : 0;
            for (int n = 0; n < PHASE_LEN; n++) random_item();
            drain();
        end

        $display("covered %0d requests and %0d computed pixels over %0d geometry phases",
                 blur_seen, pix_seen, N_PHASE);
        $display("radius 0..15, sizes 0 to over max on a banded store, pass-through and blur");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
rtl/core/bkb_pkg.sv
rtl/core/bkb_ctrl.sv
rtl/core/bkb_dp.sv
rtl/core/bokeh_kernel_blur.sv
rtl/core/bkb_chk.sv
dv/bkb_checker.sv
dv/bokeh_kernel_blur_tb.sv
